[hw/rtl/qsd_pkg.sv]
// shared types, constants, arithmetic helpers and microcode for the state derivative block
package qsd_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int STATE_ELEMENTS = 18;
  localparam int ROTORS         = 4;
  localparam int IDX_W          = 5;
  localparam int DATA_W         = 32;
  localparam int REG_W          = 31;
  localparam int PC_W           = 6;

  localparam logic signed [31:0] GRAVITY_FIXED = 32'sd642908;
  localparam logic signed [31:0] INV_SQRT2_Q30 = 32'sd759250125;
  localparam logic signed [63:0] Q_HALF        = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] Q30_HALF      = 64'sd536870912;
  localparam logic [PC_W-1:0]    PC_LAST       = 6'd52;
  localparam logic [IDX_W-1:0]   IDX_LAST      = 5'(STATE_ELEMENTS - 1);

  localparam logic [REG_W-1:0] RST_MAX_ROTOR = 31'd6553600;
  localparam logic [REG_W-1:0] RST_THRUST    = 31'd65536;
  localparam logic [REG_W-1:0] RST_YAW       = 31'd65536;
  localparam logic [REG_W-1:0] RST_ARM       = 31'd13107;
  localparam logic [REG_W-1:0] RST_MASS      = 31'd65536;
  localparam logic [REG_W-1:0] RST_INERTIA   = 31'd65536;

  typedef enum logic [1:0] {
    OP_STATE   = 2'd0,
    OP_ROTOR   = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_ROTOR = 3'd0,
    REG_THRUST    = 3'd1,
    REG_YAW       = 3'd2,
    REG_ARM       = 3'd3,
    REG_MASS      = 3'd4,
    REG_INERTIA_X = 3'd5,
    REG_INERTIA_Y = 3'd6,
    REG_INERTIA_Z = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0]       max_rotor;
    logic [REG_W-1:0]       thrust;
    logic [REG_W-1:0]       yaw;
    logic [REG_W-1:0]       arm;
    logic [REG_W-1:0]       mass;
    logic [2:0][REG_W-1:0]  inertia;
  } cfg_t;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  typedef enum logic [1:0] {PH_ISSUE, PH_MUL, PH_EXEC, PH_WAIT} phase_t;

  typedef enum logic [3:0] {
    M_LDU, M_LDW, M_A, M_ACC, M_MOM, M_MG, M_IW, M_TMP, M_CR,
    M_EMIT_RAM, M_EMIT_SUB, M_DIV_Q, M_DIV_QMG, M_DIV_CR
  } mode_t;

  typedef enum logic [4:0] {
    S_RAM, S_B, S_DY, S_A, S_L, S_M, S_ISQ2, S_G,
    S_U0, S_U1, S_U2, S_U3, S_S0, S_S1, S_S2, S_T,
    S_I0, S_I1, S_I2, S_W0, S_W1, S_W2, S_IW0, S_IW1, S_IW2
  } src_t;

  localparam int SRC_COUNT = 25;

  typedef struct packed {
    mode_t            mode;
    src_t             opa;
    src_t             opb;
    logic [IDX_W-1:0] addr;
    logic [1:0]       k;
    logic             sh30;
  } uop_t;

  typedef struct packed {
    logic                start;
    logic signed [31:0]  num;
    logic [REG_W-1:0]    den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] value;
  } emit_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  // round half up, then saturate
  function automatic logic signed [31:0] qround(input logic signed [63:0] p, input logic sh30);
    logic signed [63:0] r;
    if (sh30) r = (p + Q30_HALF) >>> 30;
    else r = (p + Q_HALF) >>> FRAC_BITS;
    return sat64(r);
  endfunction

  function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat64(64'(a) - 64'(b));
  endfunction

  function automatic uop_t mk(input mode_t m, input src_t a, input src_t b,
                              input int addr, input int k, input logic sh);
    uop_t u;
    u.mode = m;
    u.opa  = a;
    u.opb  = b;
    u.addr = IDX_W'(addr);
    u.k    = 2'(k);
    u.sh30 = sh;
    return u;
  endfunction

  // one micro step per program counter value
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(M_LDU, S_RAM, S_RAM, 0, 0, 1'b0);
      6'd1:  u = mk(M_LDU, S_RAM, S_RAM, 1, 1, 1'b0);
      6'd2:  u = mk(M_LDU, S_RAM, S_RAM, 2, 2, 1'b0);
      6'd3:  u = mk(M_LDU, S_RAM, S_RAM, 3, 3, 1'b0);
      6'd4:  u = mk(M_A, S_B, S_L, 0, 0, 1'b0);
      6'd5:  u = mk(M_A, S_A, S_ISQ2, 0, 0, 1'b1);
      6'd6:  u = mk(M_ACC, S_B, S_U0, 0, 0, 1'b0);
      6'd7:  u = mk(M_ACC, S_B, S_U1, 0, 0, 1'b0);
      6'd8:  u = mk(M_ACC, S_B, S_U2, 0, 0, 1'b0);
      6'd9:  u = mk(M_ACC, S_B, S_U3, 0, 0, 1'b0);
      6'd10: u = mk(M_MOM, S_A, S_S0, 0, 0, 1'b0);
      6'd11: u = mk(M_MOM, S_A, S_S1, 0, 1, 1'b0);
      6'd12: u = mk(M_MOM, S_DY, S_S2, 0, 2, 1'b0);
      6'd13: u = mk(M_MG, S_M, S_G, 0, 0, 1'b0);
      6'd14: u = mk(M_LDW, S_RAM, S_RAM, 15, 0, 1'b0);
      6'd15: u = mk(M_LDW, S_RAM, S_RAM, 16, 1, 1'b0);
      6'd16: u = mk(M_LDW, S_RAM, S_RAM, 17, 2, 1'b0);
      6'd17: u = mk(M_IW, S_I0, S_W0, 0, 0, 1'b0);
      6'd18: u = mk(M_IW, S_I1, S_W1, 0, 1, 1'b0);
      6'd19: u = mk(M_IW, S_I2, S_W2, 0, 2, 1'b0);
      6'd20: u = mk(M_TMP, S_W1, S_IW2, 0, 0, 1'b0);
      6'd21: u = mk(M_CR, S_W2, S_IW1, 0, 0, 1'b0);
      6'd22: u = mk(M_TMP, S_W2, S_IW0, 0, 0, 1'b0);
      6'd23: u = mk(M_CR, S_W0, S_IW2, 0, 1, 1'b0);
      6'd24: u = mk(M_TMP, S_W0, S_IW1, 0, 0, 1'b0);
      6'd25: u = mk(M_CR, S_W1, S_IW0, 0, 2, 1'b0);
      6'd26: u = mk(M_EMIT_RAM, S_RAM, S_RAM, 3, 0, 1'b0);
      6'd27: u = mk(M_EMIT_RAM, S_RAM, S_RAM, 4, 0, 1'b0);
      6'd28: u = mk(M_EMIT_RAM, S_RAM, S_RAM, 5, 0, 1'b0);
      6'd29: u = mk(M_DIV_Q, S_RAM, S_T, 8, 0, 1'b0);
      6'd30: u = mk(M_DIV_Q, S_RAM, S_T, 11, 0, 1'b0);
      6'd31: u = mk(M_DIV_QMG, S_RAM, S_T, 14, 0, 1'b0);
      6'd32: u = mk(M_TMP, S_RAM, S_W2, 7, 0, 1'b0);
      6'd33: u = mk(M_EMIT_SUB, S_RAM, S_W1, 8, 0, 1'b0);
      6'd34: u = mk(M_TMP, S_RAM, S_W0, 8, 0, 1'b0);
      6'd35: u = mk(M_EMIT_SUB, S_RAM, S_W2, 6, 0, 1'b0);
      6'd36: u = mk(M_TMP, S_RAM, S_W1, 6, 0, 1'b0);
      6'd37: u = mk(M_EMIT_SUB, S_RAM, S_W0, 7, 0, 1'b0);
      6'd38: u = mk(M_TMP, S_RAM, S_W2, 10, 0, 1'b0);
      6'd39: u = mk(M_EMIT_SUB, S_RAM, S_W1, 11, 0, 1'b0);
      6'd40: u = mk(M_TMP, S_RAM, S_W0, 11, 0, 1'b0);
      6'd41: u = mk(M_EMIT_SUB, S_RAM, S_W2, 9, 0, 1'b0);
      6'd42: u = mk(M_TMP, S_RAM, S_W1, 9, 0, 1'b0);
      6'd43: u = mk(M_EMIT_SUB, S_RAM, S_W0, 10, 0, 1'b0);
      6'd44: u = mk(M_TMP, S_RAM, S_W2, 13, 0, 1'b0);
      6'd45: u = mk(M_EMIT_SUB, S_RAM, S_W1, 14, 0, 1'b0);
      6'd46: u = mk(M_TMP, S_RAM, S_W0, 14, 0, 1'b0);
      6'd47: u = mk(M_EMIT_SUB, S_RAM, S_W2, 12, 0, 1'b0);
      6'd48: u = mk(M_TMP, S_RAM, S_W1, 12, 0, 1'b0);
      6'd49: u = mk(M_EMIT_SUB, S_RAM, S_W0, 13, 0, 1'b0);
      6'd50: u = mk(M_DIV_CR, S_RAM, S_RAM, 0, 0, 1'b0);
      6'd51: u = mk(M_DIV_CR, S_RAM, S_RAM, 0, 1, 1'b0);
      6'd52: u = mk(M_DIV_CR, S_RAM, S_RAM, 0, 2, 1'b0);
      default: u = mk(M_LDU, S_RAM, S_RAM, 0, 0, 1'b0);
    endcase
    return u;
  endfunction

endpackage

[hw/rtl/qsd_ram.sv]
// generic single write port ram with registered read
module qsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

[hw/rtl/qsd_div.sv]
// bit-serial signed fixed point divider, (num << frac) / den with saturation
module qsd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  qsd_pkg::div_req_t  req,
  output qsd_pkg::div_rsp_t  rsp
);

  localparam int DW = 32 + qsd_pkg::FRAC_BITS;
  localparam int CW = $clog2(DW + 1);

  logic                        busy_r;
  logic                        done_r;
  logic                        neg_r;
  logic [DW-1:0]               dvd_r;
  logic [qsd_pkg::REG_W-1:0]   rem_r;
  logic [qsd_pkg::REG_W-1:0]   den_r;
  logic [CW-1:0]               cnt_r;
  logic signed [31:0]          quo_r;

  logic [31:0]                 rem_sh;
  logic                        ge;
  logic [qsd_pkg::REG_W-1:0]   rem_nxt;
  logic [DW-1:0]               dvd_nxt;
  logic [31:0]                 mag_in;
  logic signed [31:0]          quo_fin;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? qsd_pkg::REG_W'(rem_sh - {1'b0, den_r}) : qsd_pkg::REG_W'(rem_sh);
    dvd_nxt = {dvd_r[DW-2:0], ge};
    mag_in  = req.num[31] ? (~req.num + 32'd1) : req.num;
    // apply sign and clip the magnitude
    if (neg_r) begin
      if (dvd_nxt > {{(DW-32){1'b0}}, 32'h8000_0000}) quo_fin = 32'sh80000000;
      else quo_fin = ~dvd_nxt[31:0] + 32'd1;
    end else begin
      if (dvd_nxt > {{(DW-32){1'b0}}, 32'h7fff_ffff}) quo_fin = 32'sh7fffffff;
      else quo_fin = dvd_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      if (req.den == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        if (req.num > 32'sd0) quo_r <= 32'sh7fffffff;
        else if (req.num < 32'sd0) quo_r <= 32'sh80000000;
        else quo_r <= 32'sd0;
      end else begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        neg_r  <= req.num[31];
        dvd_r  <= {mag_in, {qsd_pkg::FRAC_BITS{1'b0}}};
        rem_r  <= '0;
        den_r  <= req.den;
        cnt_r  <= CW'(DW);
      end
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        quo_r  <= quo_fin;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

[hw/rtl/qsd_core.sv]
// microcoded sequencer: reads the stores, one shared multiplier, divider, result emission
module qsd_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        emit_ready,
  input  qsd_pkg::cfg_t               cfg,
  input  logic [31:0]                 st_rdata,
  input  logic [31:0]                 rot_rdata,
  output logic [qsd_pkg::IDX_W-1:0]   rd_addr,
  output logic                        busy,
  output qsd_pkg::emit_t              emit
);

  qsd_pkg::state_t               state_r, state_nxt;
  qsd_pkg::phase_t               ph_r, ph_nxt;
  logic [qsd_pkg::PC_W-1:0]      pc_r, pc_nxt;
  logic [qsd_pkg::IDX_W-1:0]     out_idx_r;

  logic [qsd_pkg::REG_W-1:0]     u_r [4];
  logic signed [31:0]            a_r, mg_r, tmp_r;
  logic signed [33:0]            t_r;
  logic signed [31:0]            mom_r [3];
  logic signed [31:0]            w_r [3];
  logic signed [31:0]            iw_r [3];
  logic signed [31:0]            cr_r [3];
  logic signed [63:0]            prod_r;

  qsd_pkg::uop_t                 uop;
  logic signed [31:0]            q;
  logic signed [31:0]            srcv [qsd_pkg::SRC_COUNT];
  logic signed [33:0]            ue [4];
  logic [qsd_pkg::REG_W-1:0]     clamp_u;
  logic                          adv;
  qsd_pkg::div_req_t             div_req;
  qsd_pkg::div_rsp_t             div_rsp;

  qsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign uop     = qsd_pkg::ucode(pc_r);
  assign q       = qsd_pkg::qround(prod_r, uop.sh30);
  assign rd_addr = uop.addr;
  assign busy    = (state_r == qsd_pkg::ST_RUN);

  // rotor command clamped to [0, max]
  always_comb begin
    if (rot_rdata[31]) clamp_u = '0;
    else if (rot_rdata[30:0] > cfg.max_rotor) clamp_u = cfg.max_rotor;
    else clamp_u = rot_rdata[30:0];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ue[i] = signed'({3'b000, u_r[i]});
    end
    srcv[qsd_pkg::S_RAM]  = st_rdata;
    srcv[qsd_pkg::S_B]    = signed'({1'b0, cfg.thrust});
    srcv[qsd_pkg::S_DY]   = signed'({1'b0, cfg.yaw});
    srcv[qsd_pkg::S_A]    = a_r;
    srcv[qsd_pkg::S_L]    = signed'({1'b0, cfg.arm});
    srcv[qsd_pkg::S_M]    = signed'({1'b0, cfg.mass});
    srcv[qsd_pkg::S_ISQ2] = qsd_pkg::INV_SQRT2_Q30;
    srcv[qsd_pkg::S_G]    = qsd_pkg::GRAVITY_FIXED;
    srcv[qsd_pkg::S_U0]   = signed'({1'b0, u_r[0]});
    srcv[qsd_pkg::S_U1]   = signed'({1'b0, u_r[1]});
    srcv[qsd_pkg::S_U2]   = signed'({1'b0, u_r[2]});
    srcv[qsd_pkg::S_U3]   = signed'({1'b0, u_r[3]});
    // mixer sums, one per moment axis
    srcv[qsd_pkg::S_S0]   = qsd_pkg::sat64(64'(ue[0] + ue[1] - ue[2] - ue[3]));
    srcv[qsd_pkg::S_S1]   = qsd_pkg::sat64(64'(ue[1] + ue[2] - ue[0] - ue[3]));
    srcv[qsd_pkg::S_S2]   = qsd_pkg::sat64(64'(ue[0] - ue[1] + ue[2] - ue[3]));
    srcv[qsd_pkg::S_T]    = qsd_pkg::sat64(64'(t_r));
    srcv[qsd_pkg::S_I0]   = signed'({1'b0, cfg.inertia[0]});
    srcv[qsd_pkg::S_I1]   = signed'({1'b0, cfg.inertia[1]});
    srcv[qsd_pkg::S_I2]   = signed'({1'b0, cfg.inertia[2]});
    srcv[qsd_pkg::S_W0]   = w_r[0];
    srcv[qsd_pkg::S_W1]   = w_r[1];
    srcv[qsd_pkg::S_W2]   = w_r[2];
    srcv[qsd_pkg::S_IW0]  = iw_r[0];
    srcv[qsd_pkg::S_IW1]  = iw_r[1];
    srcv[qsd_pkg::S_IW2]  = iw_r[2];
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    pc_nxt        = pc_r;
    adv           = 1'b0;
    emit.valid    = 1'b0;
    emit.idx      = out_idx_r;
    emit.value    = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = cfg.mass;
    unique case (state_r)
      qsd_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = qsd_pkg::ST_RUN;
          ph_nxt    = qsd_pkg::PH_ISSUE;
          pc_nxt    = '0;
        end
      end
      qsd_pkg::ST_RUN: begin
        unique case (ph_r)
          qsd_pkg::PH_ISSUE: ph_nxt = qsd_pkg::PH_MUL;
          qsd_pkg::PH_MUL:   ph_nxt = qsd_pkg::PH_EXEC;
          qsd_pkg::PH_EXEC: begin
            case (uop.mode)
              qsd_pkg::M_EMIT_RAM: begin
                if (emit_ready) begin
                  emit.valid = 1'b1;
                  emit.value = st_rdata;
                  adv        = 1'b1;
                end
              end
              qsd_pkg::M_EMIT_SUB: begin
                if (emit_ready) begin
                  emit.valid = 1'b1;
                  emit.value = qsd_pkg::sub32(tmp_r, q);
                  adv        = 1'b1;
                end
              end
              qsd_pkg::M_DIV_Q: begin
                div_req.start = 1'b1;
                div_req.num   = q;
                ph_nxt        = qsd_pkg::PH_WAIT;
              end
              qsd_pkg::M_DIV_QMG: begin
                div_req.start = 1'b1;
                div_req.num   = qsd_pkg::sub32(q, mg_r);
                ph_nxt        = qsd_pkg::PH_WAIT;
              end
              qsd_pkg::M_DIV_CR: begin
                div_req.start = 1'b1;
                div_req.num   = qsd_pkg::sub32(mom_r[uop.k], cr_r[uop.k]);
                div_req.den   = cfg.inertia[uop.k];
                ph_nxt        = qsd_pkg::PH_WAIT;
              end
              default: adv = 1'b1;
            endcase
          end
          qsd_pkg::PH_WAIT: begin
            if (div_rsp.done && emit_ready) begin
              emit.valid = 1'b1;
              emit.value = div_rsp.quo;
              adv        = 1'b1;
            end
          end
          default: ph_nxt = qsd_pkg::PH_ISSUE;
        endcase
        if (adv) begin
          ph_nxt = qsd_pkg::PH_ISSUE;
          pc_nxt = pc_r + qsd_pkg::PC_W'(1);
          if (pc_r == qsd_pkg::PC_LAST) state_nxt = qsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = qsd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= qsd_pkg::ST_IDLE;
      ph_r      <= qsd_pkg::PH_ISSUE;
      pc_r      <= '0;
      out_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      pc_r    <= pc_nxt;
      if (state_r == qsd_pkg::ST_IDLE && start) out_idx_r <= '0;
      else if (emit.valid) out_idx_r <= out_idx_r + qsd_pkg::IDX_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == qsd_pkg::ST_IDLE && start) begin
      t_r <= '0;
    end
    if (ph_r == qsd_pkg::PH_MUL) begin
      prod_r <= 64'(srcv[uop.opa]) * 64'(srcv[uop.opb]);
    end
    if (state_r == qsd_pkg::ST_RUN && ph_r == qsd_pkg::PH_EXEC) begin
      case (uop.mode)
        qsd_pkg::M_LDU: u_r[uop.k]   <= clamp_u;
        qsd_pkg::M_LDW: w_r[uop.k]   <= st_rdata;
        qsd_pkg::M_A:   a_r          <= q;
        qsd_pkg::M_ACC: t_r          <= t_r + 34'(q);
        qsd_pkg::M_MOM: mom_r[uop.k] <= q;
        qsd_pkg::M_MG:  mg_r         <= q;
        qsd_pkg::M_IW:  iw_r[uop.k]  <= q;
        qsd_pkg::M_TMP: tmp_r        <= q;
        qsd_pkg::M_CR:  cr_r[uop.k]  <= qsd_pkg::sub32(tmp_r, q);
        default: ;
      endcase
    end
  end

  a_emit_running: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> state_r == qsd_pkg::ST_RUN)
    else $error("result emitted while idle");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && out_idx_r == qsd_pkg::IDX_LAST) |=> state_r == qsd_pkg::ST_IDLE)
    else $error("run continues after last result");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> ph_r == qsd_pkg::PH_WAIT && !div_rsp.done
                      || ph_r == qsd_pkg::PH_WAIT && div_rsp.done)
    else $error("divider started without entering wait");

  a_wait_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qsd_pkg::ST_RUN && ph_r == qsd_pkg::PH_WAIT) |->
      (pc_r == 6'd29 || pc_r == 6'd30 || pc_r == 6'd31 ||
       pc_r == 6'd50 || pc_r == 6'd51 || pc_r == 6'd52))
    else $error("divider wait outside a division step");

endmodule

[hw/rtl/quadrotor_state_derivative.sv]
// top level of the quadrotor rigid-body state derivative block
//
// input channel: each request carries an operation in in_tuser and an index and
// value in in_tdata. write state element and write rotor command requests go
// straight into the state store (18 entries) and rotor store (4 entries). a
// compute request starts the sequencer, which emits 18 derivative requests on
// the output channel in index order, tlast on index 17. every micro step is a
// read, multiply and write-back on the single shared 32x32 multiplier; the six
// divisions run on a bit-serial divider. in_tready is low from the compute
// request until the last result has been handed to the output register.
// a stalled receiver holds the output register, and the sequencer waits in
// its current step until the register frees up; nothing is dropped.
// reset (rst_n low, synchronous) clears the control state and loads the
// configuration defaults; the stores must be written before use. the user must
// write configuration via cfg_we/cfg_addr/cfg_wdata while idle; not enforced.
module quadrotor_state_derivative (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // element_index[4:0], element_value[36:5]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // derivative_index[4:0], derivative_value[36:5]
  output logic        out_tlast,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  qsd_pkg::cfg_t                 cfg_r;
  logic                          in_acc;
  qsd_pkg::op_t                  op;
  logic [qsd_pkg::IDX_W-1:0]     in_idx;
  logic [31:0]                   in_val;
  logic                          st_we, rot_we, start;
  logic                          busy;
  logic                          emit_ready;
  logic [qsd_pkg::IDX_W-1:0]     rd_addr;
  logic [31:0]                   st_rdata, rot_rdata;
  qsd_pkg::emit_t                emit;

  // output register
  logic                          out_valid_r;
  logic [qsd_pkg::IDX_W-1:0]     out_idx_r;
  logic [31:0]                   out_val_r;
  logic                          out_last_r;

  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;
  assign op        = qsd_pkg::op_t'(in_tuser);
  assign in_idx    = in_tdata[4:0];
  assign in_val    = in_tdata[36:5];

  // request decode, out-of-range indexes are dropped
  always_comb begin
    st_we  = 1'b0;
    rot_we = 1'b0;
    start  = 1'b0;
    if (in_acc) begin
      unique case (op)
        qsd_pkg::OP_STATE:   st_we  = in_idx < qsd_pkg::IDX_W'(qsd_pkg::STATE_ELEMENTS);
        qsd_pkg::OP_ROTOR:   rot_we = in_idx < qsd_pkg::IDX_W'(qsd_pkg::ROTORS);
        qsd_pkg::OP_COMPUTE: start  = 1'b1;
        default: ;
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_rotor  <= qsd_pkg::RST_MAX_ROTOR;
      cfg_r.thrust     <= qsd_pkg::RST_THRUST;
      cfg_r.yaw        <= qsd_pkg::RST_YAW;
      cfg_r.arm        <= qsd_pkg::RST_ARM;
      cfg_r.mass       <= qsd_pkg::RST_MASS;
      cfg_r.inertia[0] <= qsd_pkg::RST_INERTIA;
      cfg_r.inertia[1] <= qsd_pkg::RST_INERTIA;
      cfg_r.inertia[2] <= qsd_pkg::RST_INERTIA;
    end else if (cfg_we) begin
      unique case (qsd_pkg::reg_idx_t'(cfg_addr))
        qsd_pkg::REG_MAX_ROTOR: cfg_r.max_rotor  <= cfg_wdata;
        qsd_pkg::REG_THRUST:    cfg_r.thrust     <= cfg_wdata;
        qsd_pkg::REG_YAW:       cfg_r.yaw        <= cfg_wdata;
        qsd_pkg::REG_ARM:       cfg_r.arm        <= cfg_wdata;
        qsd_pkg::REG_MASS:      cfg_r.mass       <= cfg_wdata;
        qsd_pkg::REG_INERTIA_X: cfg_r.inertia[0] <= cfg_wdata;
        qsd_pkg::REG_INERTIA_Y: cfg_r.inertia[1] <= cfg_wdata;
        qsd_pkg::REG_INERTIA_Z: cfg_r.inertia[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state store: position, velocity, rotation, body rate
  qsd_ram #(
    .WIDTH (qsd_pkg::DATA_W),
    .DEPTH (qsd_pkg::STATE_ELEMENTS)
  ) u_state_ram (
    .clk     (clk),
    .we      (st_we),
    .waddr   (in_idx),
    .wdata   (in_val),
    .raddr   (rd_addr),
    .rdata_r (st_rdata)
  );

  // rotor command store
  qsd_ram #(
    .WIDTH (qsd_pkg::DATA_W),
    .DEPTH (qsd_pkg::ROTORS)
  ) u_rotor_ram (
    .clk     (clk),
    .we      (rot_we),
    .waddr   (in_idx[1:0]),
    .wdata   (in_val),
    .raddr   (rd_addr[1:0]),
    .rdata_r (rot_rdata)
  );

  assign emit_ready = !out_valid_r || out_tready;

  qsd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .emit_ready (emit_ready),
    .cfg        (cfg_r),
    .st_rdata   (st_rdata),
    .rot_rdata  (rot_rdata),
    .rd_addr    (rd_addr),
    .busy       (busy),
    .emit       (emit)
  );

  // result register, reloaded in the cycle it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_idx_r  <= emit.idx;
      out_val_r  <= emit.value;
      out_last_r <= (emit.idx == qsd_pkg::IDX_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

[bench/quadrotor_state_derivative_test.sv]
// testbench for the quadrotor state derivative block: predicts derivatives and checks results
`timescale 1ns / 1ps

module quadrotor_state_derivative_test;

  // one expected derivative
  typedef struct {
    logic [4:0]         idx;
    logic signed [31:0] value;
    logic               last;
  } deriv_t;

  // predicts the derivative set of each compute request and checks results
  class deriv_board;
    logic signed [31:0] st[18];
    logic signed [31:0] rotor[4];
    logic [30:0]        regs[8];
    deriv_t             pending[$];
    int                 errors;

    function new();
      foreach (st[i]) st[i] = 0;
      foreach (rotor[i]) rotor[i] = 0;
      regs[qsd_pkg::REG_MAX_ROTOR] = 31'd6553600;
      regs[qsd_pkg::REG_THRUST] = 31'd65536;
      regs[qsd_pkg::REG_YAW] = 31'd65536;
      regs[qsd_pkg::REG_ARM] = 31'd13107;
      regs[qsd_pkg::REG_MASS] = 31'd65536;
      regs[qsd_pkg::REG_INERTIA_X] = 31'd65536;
      regs[qsd_pkg::REG_INERTIA_Y] = 31'd65536;
      regs[qsd_pkg::REG_INERTIA_Z] = 31'd65536;
      errors = 0;
    endfunction

    function logic signed [31:0] clip(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
    endfunction

    function logic signed [31:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd32768;
      return clip(p >>> 16);
    endfunction

    function logic signed [31:0] fsub(logic signed [31:0] a, logic signed [31:0] b);
      return clip(64'(a) - 64'(b));
    endfunction

    function logic signed [31:0] fdiv(logic signed [31:0] n, logic [30:0] m);
      logic signed [63:0] q;
      if (m == 0) return (n > 0) ? 32'sh7fffffff : (n < 0) ? 32'sh80000000 : 32'sd0;
      q = (64'(n) <<< 16) / $signed({33'd0, m});
      return clip(q);
    endfunction

    function logic signed [31:0] rm(int i, int j);
      return st[6 + 3 * i + j];
    endfunction

    function void set_reg(int r, logic [30:0] v);
      regs[r] = v;
    endfunction

    function void note_request(qsd_pkg::op_t op, logic [4:0] idx, logic signed [31:0] val);
      logic signed [63:0] u[4];
      logic signed [63:0] sum, pr;
      logic signed [31:0] d[18];
      logic signed [31:0] b, dy, a, thrust, mg;
      logic signed [31:0] mom[3], w[3], iw[3], cr[3];
      deriv_t e;
      if (op == qsd_pkg::OP_STATE) begin
        if (idx < 18) st[idx] = val;
        return;
      end
      if (op == qsd_pkg::OP_ROTOR) begin
        if (idx < 4) rotor[idx] = val;
        return;
      end
      if (op != qsd_pkg::OP_COMPUTE) return;
      // clamp each rotor command to [0, max]
      for (int i = 0; i < 4; i++) begin
        u[i] = rotor[i];
        if (u[i] < 0) u[i] = 0;
        if (u[i] > $signed({33'd0, regs[qsd_pkg::REG_MAX_ROTOR]}))
          u[i] = regs[qsd_pkg::REG_MAX_ROTOR];
      end
      b = $signed({1'b0, regs[qsd_pkg::REG_THRUST]});
      dy = $signed({1'b0, regs[qsd_pkg::REG_YAW]});
      a = fmul(b, $signed({33'd0, regs[qsd_pkg::REG_ARM]}));
      pr = 64'(a) * 64'sd759250125 + 64'sd536870912;
      a = clip(pr >>> 30);
      sum = 0;
      for (int i = 0; i < 4; i++) sum += 64'(fmul(b, u[i]));
      thrust = clip(sum);
      mom[0] = fmul(a, clip(u[0] + u[1] - u[2] - u[3]));
      mom[1] = fmul(a, clip(-u[0] + u[1] + u[2] - u[3]));
      mom[2] = fmul(dy, clip(u[0] - u[1] + u[2] - u[3]));
      for (int i = 0; i < 3; i++) d[i] = st[3 + i];
      mg = fmul($signed({33'd0, regs[qsd_pkg::REG_MASS]}), 642908);
      d[3] = fdiv(fmul(rm(0, 2), thrust), regs[qsd_pkg::REG_MASS]);
      d[4] = fdiv(fmul(rm(1, 2), thrust), regs[qsd_pkg::REG_MASS]);
      d[5] = fdiv(fsub(fmul(rm(2, 2), thrust), mg), regs[qsd_pkg::REG_MASS]);
      for (int i = 0; i < 3; i++) w[i] = st[15 + i];
      for (int i = 0; i < 3; i++) begin
        d[6 + 3 * i] = fsub(fmul(rm(i, 1), w[2]), fmul(rm(i, 2), w[1]));
        d[7 + 3 * i] = fsub(fmul(rm(i, 2), w[0]), fmul(rm(i, 0), w[2]));
        d[8 + 3 * i] = fsub(fmul(rm(i, 0), w[1]), fmul(rm(i, 1), w[0]));
      end
      for (int i = 0; i < 3; i++) iw[i] = fmul($signed({33'd0, regs[5 + i]}), w[i]);
      cr[0] = fsub(fmul(w[1], iw[2]), fmul(w[2], iw[1]));
      cr[1] = fsub(fmul(w[2], iw[0]), fmul(w[0], iw[2]));
      cr[2] = fsub(fmul(w[0], iw[1]), fmul(w[1], iw[0]));
      for (int i = 0; i < 3; i++) d[15 + i] = fdiv(fsub(mom[i], cr[i]), regs[5 + i]);
      for (int k = 0; k < 18; k++) begin
        e.idx = 5'(k);
        e.value = d[k];
        e.last = (k == 17);
        pending.push_back(e);
      end
    endfunction

    function void check_result(logic [4:0] idx, logic signed [31:0] val, logic last);
      deriv_t e;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx %0d", idx));
        return;
      end
      e = pending.pop_front();
      if (idx !== e.idx || val !== e.value || last !== e.last)
        report_mismatch($sformatf("idx %0d/%0d value %h/%h last %b/%b",
                                  idx, e.idx, val, e.value, last, e.last));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // element_index[4:0], element_value[36:5]
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // derivative_index[4:0], derivative_value[36:5]
  logic        out_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [30:0] cfg_wdata;

  deriv_board board;
  int         cycles = 0;
  int         burst_left;
  int         gap_left;
  bit         hold_off;   // long receiver hold-off, driven by its own process
  int         hold_cycles;

  quadrotor_state_derivative dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // cycle counter guards against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: stalls on its own pattern, plus the hold-off stretch
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else if ((cycles / 200) % 3 == 0) out_tready <= 1'b1;  // stretches with no stall
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // sample accepted results
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[4:0], $signed(out_tdata[36:5]), out_tlast);
  end

  // hold-off process: counts its own cycles
  initial begin
    hold_off = 0;
    wait (hold_cycles > 0);
    hold_off = 1;
    repeat (hold_cycles) @(posedge clk);
    hold_off = 0;
  end

  // send one request, honoring bursts and gaps
  task automatic send_request(qsd_pkg::op_t op, logic [4:0] idx, logic signed [31:0] val);
    if (burst_left == 0) begin
      gap_left = $urandom_range(0, 4);
      burst_left = $urandom_range(1, 8);
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {3'b0, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(op, idx, val);
  endtask

  // one register write, with the enable low again before the next one
  task automatic write_reg(qsd_pkg::reg_idx_t r, logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(r, v);
  endtask

  // idle: every expected result has come, then settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom);
      default: return $signed($urandom_range(0, 262143)) - 32'sd131072;
    endcase
  endfunction

  // fill every store entry, so no unwritten entry is ever read
  task automatic load_all(bit extreme);
    for (int i = 0; i < 18; i++)
      send_request(qsd_pkg::OP_STATE, 5'(i),
                   extreme ? ((i % 2) ? 32'sh7fffffff : 32'sh80000000) : rand_val());
    for (int i = 0; i < 4; i++)
      send_request(qsd_pkg::OP_ROTOR, 5'(i), extreme ? 32'sh7fffffff : rand_val());
  endtask

  task automatic random_settings(bit ext);
    for (int r = 0; r < 8; r++) begin
      logic [30:0] v;
      if (ext) v = ($urandom_range(0, 1)) ? 31'h7fffffff : 31'd0;
      else v = 31'($urandom_range(1, 262144));
      write_reg(qsd_pkg::reg_idx_t'(r), v);
    end
  endtask

  initial begin
    int n;
    board = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    cfg_we = 0;
    cfg_addr = 0;
    cfg_wdata = 0;
    burst_left = 0;
    hold_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, ignored indexes and operation, compute at reset config
    load_all(1);
    send_request(qsd_pkg::OP_STATE, 5'd31, 32'sd5);
    send_request(qsd_pkg::OP_ROTOR, 5'd9, 32'sd5);
    send_request(qsd_pkg::op_t'(2'd3), 5'd0, 32'sd0);
    send_request(qsd_pkg::OP_ROTOR, 5'd0, 32'sh80000000);   // negative command clamps to 0
    send_request(qsd_pkg::OP_COMPUTE, 5'd31, 32'shffffffff);
    drain();
    // zero mass and inertia divide
    write_reg(qsd_pkg::REG_MASS, 31'd0);
    write_reg(qsd_pkg::REG_INERTIA_X, 31'd0);
    write_reg(qsd_pkg::REG_INERTIA_Y, 31'h7fffffff);
    write_reg(qsd_pkg::REG_INERTIA_Z, 31'd0);
    write_reg(qsd_pkg::REG_MAX_ROTOR, 31'h7fffffff);
    send_request(qsd_pkg::OP_COMPUTE, 5'd0, 32'sd0);
    drain();

    // receiver holds off while the sender keeps offering requests
    hold_cycles = 3000;
    n = 0;
    for (int phase = 0; phase < 5; phase++) begin
      random_settings(phase == 1 || phase == 4);
      load_all(0);
      n += 22;
      while (n < 30 * (phase + 1)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_request(qsd_pkg::OP_STATE, 5'($urandom_range(0, 17)), rand_val());
          3: send_request(qsd_pkg::OP_ROTOR, 5'($urandom_range(0, 3)), rand_val());
          4: send_request(qsd_pkg::op_t'($urandom_range(0, 3)), 5'($urandom),
                          $signed($urandom));
          default: send_request(qsd_pkg::OP_COMPUTE, 5'($urandom), $signed($urandom));
        endcase
        n++;
      end
      send_request(qsd_pkg::OP_COMPUTE, 5'd0, 32'sd0);
      drain();
    end
    // back to defaults for a final run
    write_reg(qsd_pkg::REG_MAX_ROTOR, 31'd6553600);
    write_reg(qsd_pkg::REG_THRUST, 31'd65536);
    write_reg(qsd_pkg::REG_YAW, 31'd65536);
    write_reg(qsd_pkg::REG_ARM, 31'd13107);
    write_reg(qsd_pkg::REG_MASS, 31'd65536);
    write_reg(qsd_pkg::REG_INERTIA_X, 31'd65536);
    write_reg(qsd_pkg::REG_INERTIA_Y, 31'd65536);
    write_reg(qsd_pkg::REG_INERTIA_Z, 31'd65536);
    send_request(qsd_pkg::OP_COMPUTE, 5'd0, 32'sd0);
    drain();
    repeat (400) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/qsd_pkg.sv
hw/rtl/qsd_ram.sv
hw/rtl/qsd_div.sv
hw/rtl/qsd_core.sv
hw/rtl/quadrotor_state_derivative.sv
bench/quadrotor_state_derivative_test.sv
